>>> sv/dual_ultrasonic_ranger_safety_core_assert.svh
// Assertion macros shared by the ranger safety RTL.
`ifndef DUAL_ULTRASONIC_RANGER_SAFETY_CORE_ASSERT_SVH
`define DUAL_ULTRASONIC_RANGER_SAFETY_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DUSR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dusr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DUSR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dusr assertion failed");

`endif

>>> sv/dusr_pkg.sv
// Package with types and constants of the dual ultrasonic ranger safety core.
`default_nettype none
package dusr_pkg;

  // Field widths.
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned DIST_W     = 15;
  localparam int unsigned GAP_W      = 20;
  localparam int unsigned TRIG_W     = 10;
  localparam int unsigned TOUT_W     = 20;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Echo conversion: cm = width / 58, saturated at CM_MAX.
  // Widths at or above CM_SAT_US saturate; below it width/58 = (width>>1)/29,
  // done as a multiplication by ceil(2^25/29) and a shift by 25.
  localparam logic [DIST_W-1:0] CM_MAX    = 15'd18078;
  localparam logic [NOW_W-1:0]  CM_SAT_US = 32'd1048582;
  localparam logic [20:0]       CM_RECIP  = 21'd1157050;
  localparam int unsigned       CM_SHIFT  = 25;

  // Reset values of the configuration registers.
  localparam logic               RST_ENABLE   = 1'b1;
  localparam logic [GAP_W-1:0]   RST_GAP      = 20'd60000;
  localparam logic [TRIG_W-1:0]  RST_TRIG     = 10'd10;
  localparam logic [TOUT_W-1:0]  RST_TOUT     = 20'd30000;
  localparam logic [LIMIT_W-1:0] RST_WALL     = 16'd20;
  localparam logic [LIMIT_W-1:0] RST_FLOOR    = 16'd10;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_ENABLE      = 3'd0,
    IDX_GAP         = 3'd1,
    IDX_TRIG_WIDTH  = 3'd2,
    IDX_ECHO_TOUT   = 3'd3,
    IDX_WALL_STOP   = 3'd4,
    IDX_FLOOR_LIMIT = 3'd5
  } dusr_cfg_idx_e;

  // Measurement phases.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_TRIG   = 2'd1,
    PH_ESTART = 2'd2,
    PH_EEND   = 2'd3
  } dusr_phase_e;

  // Configuration register set.
  typedef struct packed {
    logic               enable;
    logic [GAP_W-1:0]   gap_us;
    logic [TRIG_W-1:0]  trig_us;
    logic [TOUT_W-1:0]  tout_us;
    logic [LIMIT_W-1:0] wall_cm;
    logic [LIMIT_W-1:0] floor_cm;
  } dusr_cfg_t;

  // One result item.
  typedef struct packed {
    logic              front_trigger;
    logic              down_trigger;
    logic [DIST_W-1:0] front_distance_cm;
    logic [DIST_W-1:0] ground_distance_cm;
    logic              wall_too_close;
    logic              no_floor;
    logic              safety_warning;
  } dusr_result_t;

endpackage
`default_nettype wire

>>> sv/dusr_ifs.sv
// Valid/ready channel interfaces for input updates and result items.
`default_nettype none
interface dusr_in_if;
  import dusr_pkg::*;

  logic             valid;
  logic             ready;
  logic [NOW_W-1:0] now_us;
  logic             front_echo;
  logic             down_echo;

  modport source (output valid, now_us, front_echo, down_echo, input ready);
  modport sink   (input valid, now_us, front_echo, down_echo, output ready);
endinterface

interface dusr_out_if;
  import dusr_pkg::*;

  logic              valid;
  logic              ready;
  logic              front_trigger;
  logic              down_trigger;
  logic [DIST_W-1:0] front_distance_cm;
  logic [DIST_W-1:0] ground_distance_cm;
  logic              wall_too_close;
  logic              no_floor;
  logic              safety_warning;

  modport source (output valid, front_trigger, down_trigger, front_distance_cm,
                  ground_distance_cm, wall_too_close, no_floor, safety_warning,
                  input ready);
  modport sink   (input valid, front_trigger, down_trigger, front_distance_cm,
                  ground_distance_cm, wall_too_close, no_floor, safety_warning,
                  output ready);
endinterface
`default_nettype wire

>>> sv/dusr_echo_cm.sv
// Echo width to centimeter conversion: divide by 58 with saturation.
`default_nettype none
module dusr_echo_cm (
  input  wire logic [dusr_pkg::NOW_W-1:0]  width_us_i,
  output logic      [dusr_pkg::DIST_W-1:0] cm_o
);
  import dusr_pkg::*;

  logic [19:0] half_w;
  logic [40:0] prod;
  logic        sat;

  // Long echoes saturate; shorter ones fit in 21 bits, so halve and divide by 29.
  assign sat    = (width_us_i >= CM_SAT_US);
  assign half_w = width_us_i[20:1];
  assign prod   = 41'(half_w) * 41'(CM_RECIP);
  assign cm_o   = sat ? CM_MAX : prod[CM_SHIFT +: DIST_W];

endmodule
`default_nettype wire

>>> sv/dusr_sequencer.sv
// Measurement sequencer, distance filters and safety flags.
`default_nettype none
`include "dual_ultrasonic_ranger_safety_core_assert.svh"
module dusr_sequencer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic [dusr_pkg::NOW_W-1:0]    now_i,
  input  wire logic                          front_echo_i,
  input  wire logic                          down_echo_i,
  input  wire dusr_pkg::dusr_cfg_t           cfg_i,
  output dusr_pkg::dusr_result_t             res_o
);
  import dusr_pkg::*;

  dusr_phase_e       phase_q, phase_d;
  logic              active_q, active_d;
  logic [NOW_W-1:0]  phase_start_q, phase_start_d;
  logic [NOW_W-1:0]  echo_start_q, echo_start_d;
  logic [NOW_W-1:0]  last_done_q, last_done_d;
  logic [DIST_W-1:0] filt_q [2];
  logic [DIST_W-1:0] filt_d [2];
  logic [1:0]        valid_q, valid_d;
  logic [1:0]        ever_q, ever_d;

  logic              echo;
  logic [NOW_W-1:0]  since_done, since_phase, since_echo;
  logic [DIST_W-1:0] cm;
  logic              fin, fin_ok;
  logic [DIST_W-1:0] filt_cur;
  logic [16:0]       filt_sum;
  logic [DIST_W-1:0] filt_new;

  // Elapsed times, all modulo 2^32.
  assign echo        = active_q ? down_echo_i : front_echo_i;
  assign since_done  = now_i - last_done_q;
  assign since_phase = now_i - phase_start_q;
  assign since_echo  = now_i - echo_start_q;

  dusr_echo_cm u_echo_cm (
    .width_us_i (since_echo),
    .cm_o       (cm)
  );

  // Filter: seed with the first reading, then 3/4 old plus 1/4 new.
  assign filt_cur = active_q ? filt_q[1] : filt_q[0];
  assign filt_sum = {2'b00, filt_cur} + {1'b0, filt_cur, 1'b0} + 17'(cm);
  assign filt_new = (filt_cur == '0) ? cm : filt_sum[16:2];

  // Next state of the measurement sequence.
  always_comb begin
    phase_d       = phase_q;
    active_d      = active_q;
    phase_start_d = phase_start_q;
    echo_start_d  = echo_start_q;
    last_done_d   = last_done_q;
    filt_d[0]     = filt_q[0];
    filt_d[1]     = filt_q[1];
    valid_d       = valid_q;
    ever_d        = ever_q;
    fin           = 1'b0;
    fin_ok        = 1'b0;

    if (cfg_i.enable) begin
      case (phase_q)
        PH_IDLE: begin
          if (since_done >= NOW_W'(cfg_i.gap_us)) begin
            phase_start_d = now_i;
            phase_d       = PH_TRIG;
          end
        end
        PH_TRIG: begin
          if (since_phase >= NOW_W'(cfg_i.trig_us)) begin
            phase_start_d = now_i;
            phase_d       = PH_ESTART;
          end
        end
        PH_ESTART: begin
          if (echo) begin
            echo_start_d = now_i;
            phase_d      = PH_EEND;
          end else if (since_phase >= NOW_W'(cfg_i.tout_us)) begin
            fin = 1'b1;
          end
        end
        PH_EEND: begin
          if (!echo) begin
            fin    = 1'b1;
            fin_ok = (cm != '0);
          end else if (since_echo >= NOW_W'(cfg_i.tout_us)) begin
            fin = 1'b1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    // A finished measurement, valid or not, hands over to the other sensor.
    if (fin) begin
      ever_d[active_q]  = 1'b1;
      valid_d[active_q] = fin_ok;
      if (fin_ok) begin
        if (active_q) begin
          filt_d[1] = filt_new;
        end else begin
          filt_d[0] = filt_new;
        end
      end
      active_d    = ~active_q;
      phase_d     = PH_IDLE;
      last_done_d = now_i;
    end
  end

  // Result from the state after this update.
  always_comb begin
    res_o.front_trigger      = (phase_d == PH_TRIG) && !active_d;
    res_o.down_trigger       = (phase_d == PH_TRIG) && active_d;
    res_o.front_distance_cm  = valid_d[0] ? filt_d[0] : '0;
    res_o.ground_distance_cm = valid_d[1] ? filt_d[1] : '0;
    res_o.wall_too_close     = cfg_i.enable && valid_d[0] &&
                               ({1'b0, filt_d[0]} <= cfg_i.wall_cm);
    res_o.no_floor           = cfg_i.enable && ever_d[1] &&
                               (!valid_d[1] || ({1'b0, filt_d[1]} > cfg_i.floor_cm));
    res_o.safety_warning     = res_o.wall_too_close || res_o.no_floor;
  end

  // State registers advance once per transfer through the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      active_q      <= 1'b0;
      phase_start_q <= '0;
      echo_start_q  <= '0;
      last_done_q   <= '0;
      filt_q[0]     <= '0;
      filt_q[1]     <= '0;
      valid_q       <= '0;
      ever_q        <= '0;
    end else if (adv_i) begin
      phase_q       <= phase_d;
      active_q      <= active_d;
      phase_start_q <= phase_start_d;
      echo_start_q  <= echo_start_d;
      last_done_q   <= last_done_d;
      filt_q[0]     <= filt_d[0];
      filt_q[1]     <= filt_d[1];
      valid_q       <= valid_d;
      ever_q        <= ever_d;
    end
  end

  // A finished measurement always switches the active sensor.
  `DUSR_ASSERT_NXT(a_fin_toggles, clk_i, rst_ni, adv_i && (phase_q != PH_IDLE) && (phase_d == PH_IDLE), active_q != $past(active_q))
  // Without a transfer the sequence holds.
  `DUSR_ASSERT_NXT(a_hold_no_adv, clk_i, rst_ni, !adv_i, $stable(phase_q) && $stable(active_q) && $stable(last_done_q))
  // A valid reading never leaves a zero filter.
  `DUSR_ASSERT_IMP(a_front_valid_nz, clk_i, rst_ni, valid_q[0], filt_q[0] != '0)
  `DUSR_ASSERT_IMP(a_down_valid_nz, clk_i, rst_ni, valid_q[1], filt_q[1] != '0)

endmodule
`default_nettype wire

>>> sv/dual_ultrasonic_ranger_safety_core.sv
// Top level of the dual ultrasonic ranger safety core.
// The core takes one timestamped update per cycle while the output is not
// stalled, and returns one result per update. Each update is latched in an
// input register, passes through the sequencer logic (elapsed-time compares,
// the divide-by-58 echo conversion as a constant multiplication, and the 3/4
// filter), and lands in a result register; that single path from the state
// registers back to themselves sets the clock rate. While a result waits on a
// stalled output, one further update is held in the input register and the
// input then stalls until the result transfers. Configuration writes take
// effect on the next clock and are meant for an idle core.
`default_nettype none
`include "dual_ultrasonic_ranger_safety_core_assert.svh"
module dual_ultrasonic_ranger_safety_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [dusr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [dusr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  dusr_in_if.sink                                item_i,
  dusr_out_if.source                             result_o
);
  import dusr_pkg::*;

  dusr_cfg_t         cfg_q;
  logic              in_valid_q;
  logic [NOW_W-1:0]  now_q;
  logic              front_echo_q;
  logic              down_echo_q;
  logic              out_valid_q;
  dusr_result_t      res_q, res_d;
  logic              adv;
  logic              in_xfer;

  // An update moves on when the result register is free or being emptied.
  assign adv          = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || adv;
  assign in_xfer      = item_i.valid && item_i.ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable   <= RST_ENABLE;
      cfg_q.gap_us   <= RST_GAP;
      cfg_q.trig_us  <= RST_TRIG;
      cfg_q.tout_us  <= RST_TOUT;
      cfg_q.wall_cm  <= RST_WALL;
      cfg_q.floor_cm <= RST_FLOOR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        IDX_ENABLE:      cfg_q.enable   <= cfg_wdata_i[0];
        IDX_GAP:         cfg_q.gap_us   <= cfg_wdata_i[GAP_W-1:0];
        IDX_TRIG_WIDTH:  cfg_q.trig_us  <= cfg_wdata_i[TRIG_W-1:0];
        IDX_ECHO_TOUT:   cfg_q.tout_us  <= cfg_wdata_i[TOUT_W-1:0];
        IDX_WALL_STOP:   cfg_q.wall_cm  <= cfg_wdata_i[LIMIT_W-1:0];
        IDX_FLOOR_LIMIT: cfg_q.floor_cm <= cfg_wdata_i[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      now_q        <= item_i.now_us;
      front_echo_q <= item_i.front_echo;
      down_echo_q  <= item_i.down_echo;
    end
  end

  dusr_sequencer u_sequencer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .now_i        (now_q),
    .front_echo_i (front_echo_q),
    .down_echo_i  (down_echo_q),
    .cfg_i        (cfg_q),
    .res_o        (res_d)
  );

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid              = out_valid_q;
  assign result_o.front_trigger      = res_q.front_trigger;
  assign result_o.down_trigger       = res_q.down_trigger;
  assign result_o.front_distance_cm  = res_q.front_distance_cm;
  assign result_o.ground_distance_cm = res_q.ground_distance_cm;
  assign result_o.wall_too_close     = res_q.wall_too_close;
  assign result_o.no_floor           = res_q.no_floor;
  assign result_o.safety_warning     = res_q.safety_warning;

  // A waiting update is never dropped.
  `DUSR_ASSERT_NXT(a_in_kept, clk_i, rst_ni, in_valid_q && !adv, in_valid_q)
  // Every update that moves on shows up as a result.
  `DUSR_ASSERT_NXT(a_adv_result, clk_i, rst_ni, adv, out_valid_q)
  // An enable write lands in the register.
  `DUSR_ASSERT_NXT(a_cfg_enable, clk_i, rst_ni, cfg_we_i && (cfg_idx_i == IDX_ENABLE), cfg_q.enable == $past(cfg_wdata_i[0]))

endmodule
`default_nettype wire

>>> tb/dusr_ranger_checker.sv
// Checker for the ranger safety core: predicts every result item and compares the transfers.
module dusr_ranger_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dusr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dusr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  dusr_in_if                                   item_mon,
  dusr_out_if                                  result_mon,
  output int unsigned                          pending_o,
  output int unsigned                          fail_cnt_o,
  output int unsigned                          checked_cnt_o,
  output int unsigned                          good_meas_o,
  output int unsigned                          bad_meas_o
);
  import dusr_pkg::*;

  localparam int unsigned ECHO_US_PER_CM = 58;
  localparam int unsigned MAX_SHOWN      = 40;

  // Predicted copy of the register set and the sequencer state.
  dusr_cfg_t         cfg;
  dusr_phase_e       seq_phase;
  logic              down_active;
  logic [NOW_W-1:0]  phase_start_us;
  logic [NOW_W-1:0]  echo_start_us;
  logic [NOW_W-1:0]  done_at_us;
  logic [DIST_W-1:0] filt_cm [2];
  logic              reading_ok [2];
  logic              measured [2];

  // Results still owed by the core, oldest first.
  dusr_result_t expected_results_q [$];
  dusr_result_t got_res;
  dusr_result_t want_res;

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string msg);
    fail_cnt_o++;
    if (fail_cnt_o <= MAX_SHOWN) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  task automatic compare_field(input string name, input int unsigned got_v,
                               input int unsigned want_v);
    if (got_v != want_v) begin
      report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                checked_cnt_o, name, got_v, want_v));
    end
  endtask

  // Ends the measurement of the active sensor and hands over to the other one.
  task automatic close_measurement(input logic ok, input logic [DIST_W-1:0] cm,
                                   input logic [NOW_W-1:0] now);
    int unsigned acc;
    measured[down_active]   = 1'b1;
    reading_ok[down_active] = ok;
    if (ok) begin
      good_meas_o++;
      if (filt_cm[down_active] == '0) begin
        filt_cm[down_active] = cm;
      end else begin
        acc = (32'(filt_cm[down_active]) * 32'd3 + 32'(cm)) / 32'd4;
        filt_cm[down_active] = acc[DIST_W-1:0];
      end
    end else begin
      bad_meas_o++;
    end
    down_active = ~down_active;
    seq_phase   = PH_IDLE;
    done_at_us  = now;
  endtask

  // Advances the sequencer by one update and forms the result it causes.
  task automatic predict_update(input logic [NOW_W-1:0] now, input logic front_echo,
                                input logic down_echo, output dusr_result_t res);
    logic             echo;
    logic [NOW_W-1:0] span;
    logic [NOW_W-1:0] cm;
    logic             wall;
    logic             nofloor;
    echo = down_active ? down_echo : front_echo;
    if (cfg.enable) begin
      case (seq_phase)
        PH_IDLE: begin
          span = now - done_at_us;
          if (span >= 32'(cfg.gap_us)) begin
            phase_start_us = now;
            seq_phase      = PH_TRIG;
          end
        end
        PH_TRIG: begin
          span = now - phase_start_us;
          if (span >= 32'(cfg.trig_us)) begin
            phase_start_us = now;
            seq_phase      = PH_ESTART;
          end
        end
        PH_ESTART: begin
          span = now - phase_start_us;
          if (echo) begin
            echo_start_us = now;
            seq_phase     = PH_EEND;
          end else if (span >= 32'(cfg.tout_us)) begin
            close_measurement(1'b0, '0, now);
          end
        end
        default: begin
          // A low echo ends the pulse before the timeout is looked at.
          span = now - echo_start_us;
          if (!echo) begin
            cm = span / ECHO_US_PER_CM;
            if (cm > 32'(CM_MAX)) cm = 32'(CM_MAX);
            close_measurement(cm != '0, cm[DIST_W-1:0], now);
          end else if (span >= 32'(cfg.tout_us)) begin
            close_measurement(1'b0, '0, now);
          end
        end
      endcase
    end

    wall    = cfg.enable && reading_ok[0] && (32'(filt_cm[0]) <= 32'(cfg.wall_cm));
    nofloor = cfg.enable && measured[1] &&
              (!reading_ok[1] || (32'(filt_cm[1]) > 32'(cfg.floor_cm)));

    res.front_trigger      = (seq_phase == PH_TRIG) && !down_active;
    res.down_trigger       = (seq_phase == PH_TRIG) && down_active;
    res.front_distance_cm  = reading_ok[0] ? filt_cm[0] : '0;
    res.ground_distance_cm = reading_ok[1] ? filt_cm[1] : '0;
    res.wall_too_close     = wall;
    res.no_floor           = nofloor;
    res.safety_warning     = wall || nofloor;
  endtask

  // Register writes land in the predicted set; unknown indexes are dropped.
  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    case (idx)
      IDX_ENABLE:      cfg.enable   = data[0];
      IDX_GAP:         cfg.gap_us   = data[GAP_W-1:0];
      IDX_TRIG_WIDTH:  cfg.trig_us  = data[TRIG_W-1:0];
      IDX_ECHO_TOUT:   cfg.tout_us  = data[TOUT_W-1:0];
      IDX_WALL_STOP:   cfg.wall_cm  = data[LIMIT_W-1:0];
      IDX_FLOOR_LIMIT: cfg.floor_cm = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Watch both channels and the register port on every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.enable     = RST_ENABLE;
      cfg.gap_us     = RST_GAP;
      cfg.trig_us    = RST_TRIG;
      cfg.tout_us    = RST_TOUT;
      cfg.wall_cm    = RST_WALL;
      cfg.floor_cm   = RST_FLOOR;
      seq_phase      = PH_IDLE;
      down_active    = 1'b0;
      phase_start_us = '0;
      echo_start_us  = '0;
      done_at_us     = '0;
      filt_cm[0]     = '0;
      filt_cm[1]     = '0;
      reading_ok[0]  = 1'b0;
      reading_ok[1]  = 1'b0;
      measured[0]    = 1'b0;
      measured[1]    = 1'b0;
      expected_results_q.delete();
      fail_cnt_o     = 0;
      checked_cnt_o  = 0;
      good_meas_o    = 0;
      bad_meas_o     = 0;
      pending_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        apply_write(cfg_idx_i, cfg_wdata_i);
      end

      // Result transfer: compare with the oldest expectation first.
      if (result_mon.valid && result_mon.ready) begin
        got_res.front_trigger      = result_mon.front_trigger;
        got_res.down_trigger       = result_mon.down_trigger;
        got_res.front_distance_cm  = result_mon.front_distance_cm;
        got_res.ground_distance_cm = result_mon.ground_distance_cm;
        got_res.wall_too_close     = result_mon.wall_too_close;
        got_res.no_floor           = result_mon.no_floor;
        got_res.safety_warning     = result_mon.safety_warning;
        if (expected_results_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    checked_cnt_o));
        end else begin
          want_res = expected_results_q.pop_front();
          compare_field("front_trigger", got_res.front_trigger, want_res.front_trigger);
          compare_field("down_trigger", got_res.down_trigger, want_res.down_trigger);
          compare_field("front_distance_cm", got_res.front_distance_cm,
                        want_res.front_distance_cm);
          compare_field("ground_distance_cm", got_res.ground_distance_cm,
                        want_res.ground_distance_cm);
          compare_field("wall_too_close", got_res.wall_too_close,
                        want_res.wall_too_close);
          compare_field("no_floor", got_res.no_floor, want_res.no_floor);
          compare_field("safety_warning", got_res.safety_warning,
                        want_res.safety_warning);
        end
        checked_cnt_o++;
      end

      // Update transfer: predict the result it will cause.
      if (item_mon.valid && item_mon.ready) begin
        predict_update(item_mon.now_us, item_mon.front_echo, item_mon.down_echo, want_res);
        expected_results_q.push_back(want_res);
      end

      pending_o <= expected_results_q.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// Top of the ranger safety testbench: clock, reset, update stimulus and the verdict.
module tb_top;
  import dusr_pkg::*;

  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 116;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned CYCLE_LIMIT     = 300000;

  // Indexes past the register list; the core must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  dusr_in_if  item_ch ();
  dusr_out_if result_ch ();

  int unsigned pending;
  int unsigned fail_cnt;
  int unsigned checked_cnt;
  int unsigned good_meas;
  int unsigned bad_meas;

  int unsigned cycle_cnt = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;
  int unsigned sent_cnt = 0;
  int unsigned settings_cnt = 0;

  // Synthetic sensor scene: a running timestamp and echo pulse trains.
  logic [NOW_W-1:0] t_us = '0;
  int unsigned      step_max = 10;
  logic             echo_lvl [2];
  int unsigned      echo_run [2];

  dual_ultrasonic_ranger_safety_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_ch),
    .result_o    (result_ch)
  );

  dusr_ranger_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .item_mon      (item_ch),
    .result_mon    (result_ch),
    .pending_o     (pending),
    .fail_cnt_o    (fail_cnt),
    .checked_cnt_o (checked_cnt),
    .good_meas_o   (good_meas),
    .bad_meas_o    (bad_meas)
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one update and returns at the edge where it transfers.
  task automatic send_update(input logic [NOW_W-1:0] now, input logic front_echo,
                             input logic down_echo);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid      <= 1'b1;
    item_ch.now_us     <= now;
    item_ch.front_echo <= front_echo;
    item_ch.down_echo  <= down_echo;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // Stops offering and waits until every predicted result has transferred.
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; the write enable is dropped again before the task returns.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_enable(input logic en);
    wait_drained();
    write_reg(IDX_ENABLE, {19'($urandom), en});
  endtask

  // Loads a full register set; upper data bits beyond the enable, trigger and limit registers carry junk.
  task automatic apply_settings(input dusr_cfg_t c);
    wait_drained();
    write_reg(IDX_ENABLE, {19'($urandom), c.enable});
    write_reg(IDX_GAP, c.gap_us);
    write_reg(IDX_TRIG_WIDTH, {10'($urandom), c.trig_us});
    write_reg(IDX_ECHO_TOUT, c.tout_us);
    write_reg(IDX_WALL_STOP, {4'($urandom), c.wall_cm});
    write_reg(IDX_FLOOR_LIMIT, {4'($urandom), c.floor_cm});
    write_reg(($urandom_range(1)) ? IDX_SPARE_HI : IDX_SPARE_LO, CFG_DATA_W'($urandom));
    settings_cnt++;
  endtask

  // Next update of the scene: mostly small time steps with echo pulse trains,
  // now and then a timestamp jump, a repeated timestamp or random pin noise.
  task automatic make_update(output logic [NOW_W-1:0] now, output logic front_echo,
                             output logic down_echo);
    int unsigned pick;
    int          s;
    pick = $urandom_range(99);
    if (pick < 3) begin
      t_us = $urandom();
    end else if (pick >= 8) begin
      t_us = t_us + $urandom_range(step_max, 1);
    end
    for (s = 0; s < 2; s++) begin
      if (echo_run[s] == 0) begin
        echo_lvl[s] = ~echo_lvl[s];
        echo_run[s] = echo_lvl[s] ? $urandom_range(40, 1) : $urandom_range(60, 1);
      end else begin
        echo_run[s]--;
      end
    end
    now = t_us;
    if (pick >= 96) begin
      front_echo = 1'($urandom);
      down_echo  = 1'($urandom);
    end else begin
      front_echo = echo_lvl[0];
      down_echo  = echo_lvl[1];
    end
  endtask

  // Register set and time scale of each random phase.
  task automatic pick_phase(input int unsigned p, output dusr_cfg_t c);
    c.enable   = 1'b1;
    c.gap_us   = GAP_W'($urandom_range(300, 0));
    c.trig_us  = TRIG_W'($urandom_range(20, 0));
    c.tout_us  = TOUT_W'($urandom_range(2000, 0));
    c.wall_cm  = LIMIT_W'($urandom_range(200, 0));
    c.floor_cm = LIMIT_W'($urandom_range(200, 0));
    step_max   = 15;
    case (p)
      0: begin
        c.gap_us   = 20'd50;
        c.trig_us  = 10'd5;
        c.tout_us  = 20'd400;
        c.wall_cm  = 16'd20;
        c.floor_cm = 16'd10;
      end
      1: begin
        // Zero gap, trigger width and timeout.
        c.gap_us  = '0;
        c.trig_us = '0;
        c.tout_us = '0;
      end
      2: begin
        // Full-scale registers with a coarse time base.
        c.gap_us   = '1;
        c.trig_us  = '1;
        c.tout_us  = '1;
        c.wall_cm  = '1;
        c.floor_cm = '1;
        step_max   = 40000;
      end
      3: begin
        c.wall_cm  = '0;
        c.floor_cm = '0;
      end
      4: c.enable = 1'b0;
      default: ;
    endcase
  endtask

  initial begin
    dusr_cfg_t        c;
    logic [NOW_W-1:0] now;
    logic             fe;
    logic             de;
    int unsigned      p;
    int unsigned      i;

    item_ch.valid      <= 1'b0;
    item_ch.now_us     <= '0;
    item_ch.front_echo <= 1'b0;
    item_ch.down_echo  <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= IDX_ENABLE;
    cfg_wdata_i        <= '0;
    echo_lvl[0] = 1'b0;
    echo_lvl[1] = 1'b0;
    echo_run[0] = 0;
    echo_run[1] = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk through both sensors under the reset register values.
    send_update(32'd0, 1'b0, 1'b0);                 // gap not yet reached
    send_update(32'd60000, 1'b0, 1'b0);             // front trigger rises
    send_update(32'd60009, 1'b1, 1'b1);             // still inside the trigger width
    send_update(32'd60010, 1'b0, 1'b0);             // waiting for the echo
    send_update(32'd60011, 1'b1, 1'b0);             // echo starts
    send_update(32'd61751, 1'b0, 1'b1);             // 30 cm seeds the front filter
    send_update(32'd121751, 1'b0, 1'b0);            // down trigger rises
    // Disabled while the trigger is high: everything freezes.
    set_enable(1'b0);
    send_update(32'd121800, 1'b0, 1'b1);
    send_update(32'd200000, 1'b1, 1'b1);
    set_enable(1'b1);
    send_update(32'd121761, 1'b0, 1'b1);            // trigger ends
    send_update(32'd121762, 1'b0, 1'b1);            // echo already high counts as start
    send_update(32'd122052, 1'b0, 1'b0);            // 5 cm on the down sensor
    send_update(32'd182052, 1'b0, 1'b0);
    send_update(32'd182062, 1'b0, 1'b0);
    send_update(32'd212062, 1'b0, 1'b0);            // no echo start: front invalid
    send_update(32'd272062, 1'b0, 1'b0);
    send_update(32'd272072, 1'b0, 1'b0);
    send_update(32'd272073, 1'b0, 1'b1);
    send_update(32'd302073, 1'b0, 1'b1);            // echo never ends: no floor
    send_update(32'd362073, 1'b0, 1'b0);
    send_update(32'd362083, 1'b0, 1'b0);
    send_update(32'd362084, 1'b1, 1'b0);
    send_update(32'd362084 + 32'h8000_0000, 1'b0, 1'b0);  // huge width saturates
    send_update(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_update(32'h0000_0009, 1'b1, 1'b1);         // elapsed time wraps
    send_update(32'h0000_000A, 1'b0, 1'b1);
    send_update(32'h0000_000A, 1'b0, 1'b0);         // zero width is invalid

    // Random phases, each with its own registers and idling pattern.
    for (p = 0; p < NUM_PHASES; p++) begin
      pick_phase(p, c);
      apply_settings(c);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Long receiver hold-off while updates keep coming.
        if (p == 0 && i == 30) hold_req = 1'b1;
        // Mid-phase pause until every result is back.
        if (p == 5 && i == 50) wait_drained();
        make_update(now, fe, de);
        send_update(now, fe, de);
      end
    end

    wait_drained();

    $display("Covered %0d updates under %0d register sets: zero and full-scale limits,",
             sent_cnt, settings_cnt);
    $display("a frozen sequence, timestamp wrap; %0d results compared, %0d good and %0d failed readings.",
             checked_cnt, good_meas, bad_meas);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
